@@ rtl/pds_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pds_pkg
// Shared types and constants for the percent-decode stream block.
// ----------------------------------------------------------------------------
package pds_pkg;

    // Most output bytes that one input byte can cause.
    localparam int RUN_MAX = 3;

    // Default depth of the queue between the front and the back.
    localparam int QUEUE_DEPTH = 2;

    // One run of output bytes, as the front hands it to the back.
    typedef struct packed {
        logic [RUN_MAX-1:0][7:0] data;
        logic [1:0]              count;
        logic                    str_end;
    } pds_run_t;

endpackage

@@ rtl/pds_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pds_front
// Accepts input bytes, tracks the escape phase and builds output runs.
// ----------------------------------------------------------------------------
module pds_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [7:0]        in_byte,
    input  logic              in_end,
    input  logic              q_ready,
    output logic              q_push,
    output pds_pkg::pds_run_t q_run
);
    import pds_pkg::*;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_PCT  = 2'd1,
        PH_DIG  = 2'd2
    } phase_t;

    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_PLUS  = 8'h2b;
    localparam logic [7:0] CH_SPACE = 8'h20;

    function automatic logic is_hex(input logic [7:0] c);
        return (c >= 8'd48 && c <= 8'd57) || (c >= 8'd97 && c <= 8'd102) ||
               (c >= 8'd65 && c <= 8'd70);
    endfunction

    function automatic logic [3:0] hex_val(input logic [7:0] c);
        logic [7:0] t;
        t = 8'd0;
        if (c >= 8'd48 && c <= 8'd57)
            t = c - 8'd48;
        else if (c >= 8'd97 && c <= 8'd102)
            t = c - 8'd87;
        else if (c >= 8'd65 && c <= 8'd70)
            t = c - 8'd55;
        return t[3:0];
    endfunction

    // Alphanumerics plus the URL-safe and reserved symbols
    function automatic logic is_safe(input logic [7:0] v);
        return (v >= 8'd48 && v <= 8'd57) || (v >= 8'd97 && v <= 8'd122) ||
               (v >= 8'd65 && v <= 8'd90) || v == 8'h21 || v == 8'h24 ||
               (v >= 8'h26 && v <= 8'h2f) || v == 8'h3a || v == 8'h3b ||
               v == 8'h3d || v == 8'h3f || v == 8'h40 || v == 8'h5f;
    endfunction

    phase_t     phase_reg, phase_next;
    logic [7:0] held_reg, held_next;
    pds_run_t   run;
    logic [1:0] n;
    logic [7:0] dec;
    logic       fresh;
    logic       accept;

    assign accept   = in_valid && q_ready;
    assign in_ready = q_ready;
    assign dec      = {hex_val(held_reg), hex_val(in_byte)};

    always_comb
    begin
        run        = '0;
        n          = 2'd0;
        phase_next = phase_reg;
        held_next  = held_reg;
        fresh      = 1'b0;

        unique case (phase_reg)
            PH_PCT:
            begin
                if (is_hex(in_byte))
                begin
                    held_next  = in_byte;
                    phase_next = PH_DIG;
                end
                else
                begin
                    run.data[n] = CH_PCT;
                    n           = n + 2'd1;
                    phase_next  = PH_IDLE;
                    fresh       = 1'b1;
                end
            end
            PH_DIG:
            begin
                phase_next = PH_IDLE;
                if (is_hex(in_byte))
                begin
                    if (!is_safe(dec))
                    begin
                        run.data[n] = dec;
                        n           = n + 2'd1;
                    end
                    else
                    begin
                        // safe byte: keep the escape as written
                        run.data[0] = CH_PCT;
                        run.data[1] = held_reg;
                        run.data[2] = in_byte;
                        n           = 2'd3;
                    end
                end
                else
                begin
                    run.data[0] = CH_PCT;
                    run.data[1] = held_reg;
                    n           = 2'd2;
                    fresh       = 1'b1;
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
                fresh      = 1'b1;
            end
        endcase

        if (fresh)
        begin
            if (in_byte == CH_PLUS)
            begin
                run.data[n] = CH_SPACE;
                n           = n + 2'd1;
            end
            else if (in_byte == CH_PCT)
                phase_next = PH_PCT;
            else
            begin
                run.data[n] = in_byte;
                n           = n + 2'd1;
            end
        end

        // flush a pending escape at end of string
        if (in_end)
        begin
            if (phase_next == PH_PCT)
            begin
                run.data[n] = CH_PCT;
                n           = n + 2'd1;
            end
            else if (phase_next == PH_DIG)
            begin
                run.data[n]        = CH_PCT;
                run.data[n + 2'd1] = held_next;
                n                  = n + 2'd2;
            end
            phase_next = PH_IDLE;
            held_next  = 8'd0;
        end

        run.count   = n;
        run.str_end = in_end;
    end

    assign q_push = accept && (n != 2'd0);
    assign q_run  = run;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            held_reg  <= 8'd0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            held_reg  <= held_next;
        end
    end

endmodule

@@ rtl/pds_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pds_queue
// Small FIFO of output runs between the front and the back.
// ----------------------------------------------------------------------------
module pds_queue #(
    parameter int DEPTH = pds_pkg::QUEUE_DEPTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  pds_pkg::pds_run_t push_run,
    output logic              push_ready,
    input  logic              pop,
    output logic              head_valid,
    output pds_pkg::pds_run_t head_run
);
    import pds_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

    pds_run_t      mem [DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] cnt_reg;
    logic          do_push, do_pop;

    assign push_ready = (cnt_reg != CNT_FULL);
    assign head_valid = (cnt_reg != '0);
    assign head_run   = mem[rd_ptr_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && head_valid;

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push_run;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                cnt_reg <= cnt_reg + 1'b1;
            else if (do_pop && !do_push)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

endmodule

@@ rtl/pds_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pds_back
// Serializes queued runs into single output bytes through an output register.
// ----------------------------------------------------------------------------
module pds_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              head_valid,
    input  pds_pkg::pds_run_t head_run,
    output logic              pop,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [7:0]        out_byte,
    output logic              run_last,
    output logic              string_done
);
    import pds_pkg::*;

    logic [1:0] pos_reg;
    logic       out_valid_reg;
    logic [7:0] out_byte_reg;
    logic       run_last_reg, string_done_reg;
    logic       load, last;

    assign load = head_valid && (!out_valid_reg || out_ready);
    assign last = (pos_reg == head_run.count - 2'd1);
    assign pop  = load && last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                out_valid_reg <= 1'b1;
                pos_reg       <= last ? 2'd0 : pos_reg + 2'd1;
            end
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_byte_reg    <= head_run.data[pos_reg];
            run_last_reg    <= last;
            string_done_reg <= last && head_run.str_end;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_byte    = out_byte_reg;
    assign run_last    = run_last_reg;
    assign string_done = string_done_reg;

endmodule

@@ rtl/percent_decode_stream.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// percent_decode_stream
// Streaming URL percent decoder, one encoded byte per request.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready) carries one encoded byte and an end of
// string flag. Output channel (out_valid/out_ready) carries decoded bytes;
// run_last marks the final byte caused by one input byte and string_done the
// final byte of a string. An input byte may cause zero to three outputs.
// A result byte passes through the run queue and then the output register.
// Throughput: one input byte per cycle while each causes at most one output
// and the receiver keeps up; the serializer in the back sends one byte per
// cycle, so a byte with more outputs holds the output side longer. The run
// queue between front and back absorbs that; in_ready drops only when full.
// Reset clears the escape phase, the held digit and the queue; no output is
// pending afterwards. When the receiver stalls, the output register holds its
// byte, the queue fills and then in_ready goes low until space frees.
// ----------------------------------------------------------------------------
module percent_decode_stream #(
    parameter int QDEPTH = pds_pkg::QUEUE_DEPTH
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    input  logic       in_end,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       run_last,
    output logic       string_done
);
    import pds_pkg::*;

    pds_run_t q_in_run, q_head_run;
    logic     q_push, q_ready, q_pop, q_head_valid;

    pds_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_byte  (in_byte),
        .in_end   (in_end),
        .q_ready  (q_ready),
        .q_push   (q_push),
        .q_run    (q_in_run)
    );

    pds_queue #(
        .DEPTH (QDEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_run   (q_in_run),
        .push_ready (q_ready),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head_run   (q_head_run)
    );

    pds_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_valid  (q_head_valid),
        .head_run    (q_head_run),
        .pop         (q_pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_byte    (out_byte),
        .run_last    (run_last),
        .string_done (string_done)
    );

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for percent_decode_stream.
// ----------------------------------------------------------------------------
// A scoreboard follows the escape phase and the held digit of the decoder.
// Each accepted request is turned into the run of decoded bytes that it
// should cause, and every byte taken on the output channel is checked
// against the oldest one waiting. Stimulus is a directed set of escapes,
// broken escapes and end-of-string flushes, then random strings built mostly
// from well-formed escapes with noise mixed in. The sender works in bursts
// and the receiver stalls in windows of varying density.
// ----------------------------------------------------------------------------

typedef enum logic [1:0] {
    ESC_IDLE    = 2'd0,
    ESC_PERCENT = 2'd1,
    ESC_DIGIT   = 2'd2
} esc_phase_t;

typedef struct packed {
    logic [7:0] data;
    logic       run_last;
    logic       string_done;
} decoded_t;

localparam logic [7:0] CH_PERCENT = 8'h25;
localparam logic [7:0] CH_PLUS    = 8'h2B;
localparam logic [7:0] CH_SPACE   = 8'h20;

class decode_scoreboard;
    esc_phase_t phase;
    logic [7:0] held_digit;
    decoded_t   run_q[$];
    decoded_t   expected_bytes[$];
    int         error_count;

    function new();
        phase       = ESC_IDLE;
        held_digit  = 8'h00;
        error_count = 0;
    endfunction

    function bit is_hex_digit(logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
               (c >= 8'h41 && c <= 8'h46);
    endfunction

    function logic [3:0] hex_value(logic [7:0] c);
        logic [7:0] v;
        v = 8'h00;
        if (c >= 8'h30 && c <= 8'h39)
            v = c - 8'h30;
        else if (c >= 8'h61 && c <= 8'h66)
            v = c - 8'h61 + 8'd10;
        else if (c >= 8'h41 && c <= 8'h46)
            v = c - 8'h41 + 8'd10;
        return v[3:0];
    endfunction

    // Alphanumerics and the URL reserved/unreserved symbols stay escaped.
    function bit is_url_safe(logic [7:0] v);
        if (v >= 8'h30 && v <= 8'h39) return 1'b1;
        if (v >= 8'h61 && v <= 8'h7A) return 1'b1;
        if (v >= 8'h41 && v <= 8'h5A) return 1'b1;
        if (v == 8'h21 || v == 8'h24) return 1'b1;
        if (v >= 8'h26 && v <= 8'h2F) return 1'b1;
        if (v == 8'h3A || v == 8'h3B || v == 8'h3D || v == 8'h3F ||
            v == 8'h40 || v == 8'h5F) return 1'b1;
        return 1'b0;
    endfunction

    function void add_byte(logic [7:0] b);
        decoded_t d;
        d.data        = b;
        d.run_last    = 1'b0;
        d.string_done = 1'b0;
        if (run_q.size() < 3)
            run_q.push_back(d);
    endfunction

    function void take_fresh(logic [7:0] b);
        if (b == CH_PLUS)
            add_byte(CH_SPACE);
        else if (b == CH_PERCENT)
            phase = ESC_PERCENT;
        else
            add_byte(b);
    endfunction

    function void note_request(logic [7:0] b, logic last);
        logic [7:0] v;
        run_q.delete();
        case (phase)
            ESC_PERCENT:
                if (is_hex_digit(b))
                begin
                    held_digit = b;
                    phase      = ESC_DIGIT;
                end
                else
                begin
                    add_byte(CH_PERCENT);
                    phase = ESC_IDLE;
                    take_fresh(b);
                end
            ESC_DIGIT:
                if (is_hex_digit(b))
                begin
                    v     = {hex_value(held_digit), hex_value(b)};
                    phase = ESC_IDLE;
                    if (!is_url_safe(v))
                        add_byte(v);
                    else
                    begin
                        add_byte(CH_PERCENT);
                        add_byte(held_digit);
                        add_byte(b);
                    end
                end
                else
                begin
                    add_byte(CH_PERCENT);
                    add_byte(held_digit);
                    phase = ESC_IDLE;
                    take_fresh(b);
                end
            default:
            begin
                phase = ESC_IDLE;
                take_fresh(b);
            end
        endcase
        if (last)
        begin
            // flush a pending escape at end of string
            if (phase == ESC_PERCENT)
                add_byte(CH_PERCENT);
            else if (phase == ESC_DIGIT)
            begin
                add_byte(CH_PERCENT);
                add_byte(held_digit);
            end
            phase      = ESC_IDLE;
            held_digit = 8'h00;
        end
        if (run_q.size() > 0)
        begin
            run_q[run_q.size()-1].run_last    = 1'b1;
            run_q[run_q.size()-1].string_done = last;
        end
        foreach (run_q[i])
            expected_bytes.push_back(run_q[i]);
    endfunction

    function void check_result(logic [7:0] data, logic rl, logic sd);
        decoded_t want;
        if (expected_bytes.size() == 0)
        begin
            $error("unexpected output byte 0x%02h", data);
            error_count++;
            return;
        end
        want = expected_bytes.pop_front();
        if (want.data !== data)
        begin
            $error("out_byte: expected 0x%02h, actual 0x%02h", want.data, data);
            error_count++;
        end
        if (want.run_last !== rl)
        begin
            $error("run_last: expected %0b, actual %0b", want.run_last, rl);
            error_count++;
        end
        if (want.string_done !== sd)
        begin
            $error("string_done: expected %0b, actual %0b", want.string_done, sd);
            error_count++;
        end
    endfunction

    function int outstanding();
        return expected_bytes.size();
    endfunction
endclass

module tb;

    localparam int LIMIT_CYCLES = 200000;
    localparam int RANDOM_ITEMS = 250;

    typedef enum int {
        TOK_ESCAPE,
        TOK_PLAIN,
        TOK_PLUS,
        TOK_BROKEN,
        TOK_NOISE
    } token_t;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic [7:0] in_byte;
    logic       in_end;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [7:0] out_byte;
    logic       run_last;
    logic       string_done;

    decode_scoreboard sb = new();

    int cycle_count = 0;
    int burst_left  = 0;
    int items_sent  = 0;
    int stall_window = 0;
    int stall_pct    = 0;
    bit paused_once  = 0;

    percent_decode_stream dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_byte     (in_byte),
        .in_end      (in_end),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_byte    (out_byte),
        .run_last    (run_last),
        .string_done (string_done)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Receiver: stall density changes from window to window, including
    // windows with no stalls at all.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
                sb.check_result(out_byte, run_last, string_done);
            if (stall_window == 0)
            begin
                stall_window <= $urandom_range(10, 80);
                case ($urandom_range(0, 3))
                    0: stall_pct <= 0;
                    1: stall_pct <= 25;
                    2: stall_pct <= 60;
                    default: stall_pct <= 90;
                endcase
            end
            else
                stall_window <= stall_window - 1;
            out_ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        in_byte  <= b;
        in_end   <= last;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_request(b, last);
        items_sent++;
    endtask

    task automatic send_text(input string s, input logic end_last);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], end_last && (i == s.len() - 1));
    endtask

    // Hold the sender off until every expected byte has come out.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.outstanding() != 0)
            @(posedge clk);
    endtask

    function automatic logic [7:0] hex_char(int v, bit upper);
        if (v < 10)
            return 8'(8'h30 + v);
        return 8'((upper ? 8'h41 : 8'h61) + v - 10);
    endfunction

    function automatic logic [7:0] pick_non_hex();
        logic [7:0] v;
        do
            v = 8'($urandom_range(0, 255));
        while (sb.is_hex_digit(v));
        return v;
    endfunction

    // One random string: mostly escapes with random digits, some plain
    // text, broken or cut-off escapes and raw noise.
    task automatic send_random_string();
        logic [7:0] bytes_q[$];
        logic [7:0] v;
        token_t     kind;
        int         pick;
        int         n_tokens;
        bit         cut;
        n_tokens = $urandom_range(1, 8);
        cut      = 0;
        for (int t = 0; t < n_tokens && !cut; t++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 40)      kind = TOK_ESCAPE;
            else if (pick < 60) kind = TOK_PLAIN;
            else if (pick < 70) kind = TOK_PLUS;
            else if (pick < 85) kind = TOK_BROKEN;
            else                kind = TOK_NOISE;
            case (kind)
                TOK_ESCAPE:
                begin
                    v = 8'($urandom_range(0, 255));
                    bytes_q.push_back(CH_PERCENT);
                    bytes_q.push_back(hex_char(v[7:4], 1'($urandom_range(0, 1))));
                    bytes_q.push_back(hex_char(v[3:0], 1'($urandom_range(0, 1))));
                end
                TOK_PLAIN:
                begin
                    do
                        v = 8'($urandom_range(8'h21, 8'h7E));
                    while (v == CH_PERCENT || v == CH_PLUS);
                    bytes_q.push_back(v);
                end
                TOK_PLUS:
                    bytes_q.push_back(CH_PLUS);
                TOK_BROKEN:
                begin
                    bytes_q.push_back(CH_PERCENT);
                    case ($urandom_range(0, 2))
                        0: bytes_q.push_back(pick_non_hex());
                        1:
                        begin
                            bytes_q.push_back(hex_char($urandom_range(0, 15),
                                                       1'($urandom_range(0, 1))));
                            bytes_q.push_back(pick_non_hex());
                        end
                        default:
                        begin
                            // cut off by the end of the string
                            if ($urandom_range(0, 1))
                                bytes_q.push_back(hex_char($urandom_range(0, 15),
                                                           1'($urandom_range(0, 1))));
                            cut = 1;
                        end
                    endcase
                end
                default:
                    bytes_q.push_back(8'($urandom_range(0, 255)));
            endcase
        end
        foreach (bytes_q[i])
            send_byte(bytes_q[i],
                      (i == bytes_q.size() - 1) ? ($urandom_range(0, 9) != 0)
                                                : ($urandom_range(0, 49) == 0));
    endtask

    initial
    begin
        rst_n    <= 1'b0;
        in_valid <= 1'b0;
        in_byte  <= 8'h00;
        in_end   <= 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // plus, safe escape, decoded escape, mixed-case digits,
        // percent after percent, non-hex after percent and after a digit
        send_text("+%41%20%fF%%z%4g", 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        // flushes at end of string with one or two characters pending
        send_text("%A", 1'b1);
        send_text("%4%", 1'b1);
        send_text("%", 1'b1);
        // decoded percent does not open a new escape
        send_text("%2541", 1'b1);

        drain();

        while (items_sent < RANDOM_ITEMS)
        begin
            send_random_string();
            if (!paused_once && items_sent > 150)
            begin
                paused_once = 1;
                drain();
            end
        end

        drain();
        repeat (20) @(posedge clk);
        if (sb.error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
